FILE: rtl/lgu_pkg.sv
// ----------------------------------------------------------------------------
// lgu_pkg: shared definitions for the loss gradient unit
// Loss kind codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lgu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EPS_W         = 16;
	localparam int KIND_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	typedef enum logic [KIND_W-1:0] {
		LK_LOGISTIC = 2'd0,
		LK_XENT     = 2'd1,
		LK_MSE      = 2'd2,
		LK_PASS     = 2'd3
	} loss_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOSS_KIND = 2'd0,
		REG_EPS_FLOOR = 2'd1
	} cfg_reg_t;

	localparam logic [EPS_W-1:0] EPS_FLOOR_RST = 16'd1;

endpackage : lgu_pkg

`default_nettype wire

FILE: rtl/loss_gradient_unit.sv
// ----------------------------------------------------------------------------
// loss_gradient_unit: elementwise loss gradient
// Per item, takes a prediction h and a label y (unsigned, FRAC_BITS fraction
// bits, inputs above one saturate) and returns the gradient with respect to h
// in signed fixed point: logistic (h-y)/max(h(1-h),floor), cross-entropy
// -y/max(h,floor), mean squared error h-y, pass-through h. Quotients truncate toward zero.
//
// Channels: input (in_valid/in_stall, prediction, label), output
// (out_valid/out_stall, gradient), and a register write port
// (cfg_valid/cfg_ready, cfg_index, cfg_data) that is always ready; write it
// only while no item is in flight.
// From input transfer to output, an item passes through three setup stages
// (saturate, multiply, operand select), one restoring divider stage per
// quotient bit (2*FRAC_BITS+1 of them), and the output register. One item
// is accepted every cycle while in_stall is low.
// Reset clears all valid bits and sets the registers to logistic mode with a
// floor of one LSB. When the receiver stalls, one more result lands in a skid
// register, then in_stall rises and the whole pipeline holds until the skid
// drains; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module loss_gradient_unit
	import lgu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [FRAC_BITS:0]      prediction,
	input  wire logic [FRAC_BITS:0]      label,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [2*FRAC_BITS+1:0] gradient,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int IN_W   = FRAC_BITS + 1;
	localparam int OUT_W  = 2 * FRAC_BITS + 2;
	localparam int NUM_W  = 2 * FRAC_BITS + 1;
	localparam int PROD_W = 2 * IN_W;
	localparam int DIV_W  = (IN_W > EPS_W) ? IN_W : EPS_W;
	localparam logic [IN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// registers
	loss_kind_t       loss_kind_q;
	logic [EPS_W-1:0] eps_floor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_kind_q <= LK_LOGISTIC;
			eps_floor_q <= EPS_FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_LOSS_KIND) begin
				loss_kind_q <= loss_kind_t'(cfg_data[KIND_W-1:0]);
			end else if (cfg_index == REG_EPS_FLOOR) begin
				eps_floor_q <= cfg_data[EPS_W-1:0];
			end
		end
	end

	// pipeline control
	logic en;
	logic skid_valid_q;
	logic out_valid_q;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// stage 1: saturate inputs, latch mode and floor
	logic             v_s1;
	logic [IN_W-1:0]  h_s1, y_s1;
	loss_kind_t       kind_s1;
	logic [DIV_W-1:0] floor_s1;

	// stage 2: h*(1-h), difference
	logic             v_s2;
	logic [IN_W-1:0]  h_s2, y_s2, diff_s2, denom_s2;
	logic             neg_s2;
	loss_kind_t       kind_s2;
	logic [DIV_W-1:0] floor_s2;

	logic [PROD_W-1:0] prod;
	assign prod = PROD_W'(h_s1) * PROD_W'(ONE - h_s1);

	// divider pipe; index 0 is stage 3
	logic             dv_v_s   [NUM_W+1];
	logic             dv_op_s  [NUM_W+1];
	logic             dv_neg_s [NUM_W+1];
	logic [OUT_W-1:0] dv_byp_s [NUM_W+1];
	logic [DIV_W-1:0] dv_rem_s [NUM_W+1];
	logic [DIV_W-1:0] dv_dvs_s [NUM_W+1];
	logic [NUM_W-1:0] dv_nq_s  [NUM_W+1];

	// stage 3 operand select
	logic             op_c, neg_c;
	logic [OUT_W-1:0] byp_c;
	logic [DIV_W-1:0] dvs_c;
	logic [NUM_W-1:0] nq_c;
	logic [DIV_W-1:0] denom_w, h_w;

	always_comb begin
		denom_w = DIV_W'(denom_s2);
		h_w     = DIV_W'(h_s2);
		op_c    = 1'b0;
		neg_c   = 1'b0;
		byp_c   = '0;
		dvs_c   = floor_s2;
		nq_c    = '0;
		unique case (kind_s2)
			LK_LOGISTIC: begin
				if (h_s2 != y_s2) begin
					op_c  = 1'b1;
					neg_c = neg_s2;
					dvs_c = (denom_w < floor_s2) ? floor_s2 : denom_w;
					nq_c  = {diff_s2, {FRAC_BITS{1'b0}}};
				end
			end
			LK_XENT: begin
				if (y_s2 != '0) begin
					op_c  = 1'b1;
					neg_c = 1'b1;
					dvs_c = (h_w < floor_s2) ? floor_s2 : h_w;
					nq_c  = {y_s2, {FRAC_BITS{1'b0}}};
				end
			end
			LK_MSE: begin
				byp_c = neg_s2 ? (OUT_W'(0) - OUT_W'(diff_s2)) : OUT_W'(diff_s2);
			end
			LK_PASS: begin
				byp_c = OUT_W'(h_s2);
			end
			default: begin
				byp_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			dv_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1     <= (prediction > ONE) ? ONE : prediction;
			y_s1     <= (label > ONE) ? ONE : label;
			kind_s1  <= loss_kind_q;
			floor_s1 <= DIV_W'((eps_floor_q == '0) ? EPS_W'(1) : eps_floor_q);

			h_s2     <= h_s1;
			y_s2     <= y_s1;
			neg_s2   <= h_s1 < y_s1;
			diff_s2  <= (h_s1 < y_s1) ? (y_s1 - h_s1) : (h_s1 - y_s1);
			denom_s2 <= prod[FRAC_BITS +: IN_W];
			kind_s2  <= kind_s1;
			floor_s2 <= floor_s1;

			dv_op_s[0]  <= op_c;
			dv_neg_s[0] <= neg_c;
			dv_byp_s[0] <= byp_c;
			dv_rem_s[0] <= '0;
			dv_dvs_s[0] <= dvs_c;
			dv_nq_s[0]  <= nq_c;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic [DIV_W:0] trial;
		logic [DIV_W:0] sub;
		logic           ge;

		always_comb begin
			trial = {dv_rem_s[k], dv_nq_s[k][NUM_W-1]};
			sub   = trial - {1'b0, dv_dvs_s[k]};
			ge    = trial >= {1'b0, dv_dvs_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_op_s[k+1]  <= dv_op_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_byp_s[k+1] <= dv_byp_s[k];
				dv_dvs_s[k+1] <= dv_dvs_s[k];
				dv_rem_s[k+1] <= ge ? sub[DIV_W-1:0] : trial[DIV_W-1:0];
				dv_nq_s[k+1]  <= {dv_nq_s[k][NUM_W-2:0], ge};
			end
		end
	end

	// result format, output register and skid
	logic [OUT_W-1:0] res;
	logic [OUT_W-1:0] quo;
	logic [OUT_W-1:0] out_q, skid_q;
	logic             arrive, pop, load_out, load_skid, drain;

	always_comb begin
		quo       = OUT_W'(dv_nq_s[NUM_W]);
		res       = dv_op_s[NUM_W] ? (dv_neg_s[NUM_W] ? (OUT_W'(0) - quo) : quo)
		                           : dv_byp_s[NUM_W];
		arrive    = en && dv_v_s[NUM_W];
		pop       = out_valid_q && !out_stall;
		drain     = skid_valid_q && pop;
		load_out  = arrive && (!out_valid_q || pop);
		load_skid = arrive && out_valid_q && !pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
			if (load_out || load_skid) begin
				out_valid_q <= 1'b1;
			end else if (pop && !skid_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign gradient  = $signed(out_q);

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without a stalled output");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[NUM_W] && dv_op_s[NUM_W] |-> dv_rem_s[NUM_W] < dv_dvs_s[NUM_W])
		else $error("divider remainder not below divisor");

endmodule : loss_gradient_unit

`default_nettype wire

FILE: tb/lgu_gradient_checker.sv
// ----------------------------------------------------------------------------
// lgu_gradient_checker: gradient prediction and compare for loss_gradient_unit
// Watches the register write port, the input channel and the output channel.
// Keeps its own copy of the loss kind and the divisor floor, computes the
// expected gradient for every input transfer, queues it, and compares every
// output transfer against the oldest queued gradient. Exports the number of
// gradients still awaited and the number of failures seen.
// ----------------------------------------------------------------------------
module lgu_gradient_checker
	import lgu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [FRAC_BITS:0]       prediction,
	input  logic [FRAC_BITS:0]       label,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [2*FRAC_BITS+1:0]   gradient,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       errors,
	output int                       in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W  = FRAC_BITS + 1;
	localparam int OUT_W = 2 * FRAC_BITS + 2;
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

	loss_kind_t        kind_q;
	logic [EPS_W-1:0]  floor_q;
	logic [OUT_W-1:0]  grad_q[$];
	int                err_cnt = 0;

	function automatic logic [OUT_W-1:0] loss_grad(logic [IN_W-1:0] h_in, logic [IN_W-1:0] y_in,
			loss_kind_t kind, logic [EPS_W-1:0] floor_in);
		logic [63:0] h, y, fl, den, mag;
		logic        neg;
		h   = (64'(h_in) > ONE) ? ONE : 64'(h_in);
		y   = (64'(y_in) > ONE) ? ONE : 64'(y_in);
		fl  = (floor_in == '0) ? 64'd1 : 64'(floor_in);
		mag = 64'd0;
		neg = 1'b0;
		case (kind)
			LK_LOGISTIC: begin
				if (h != y) begin
					den = (h * (ONE - h)) >> FRAC_BITS;
					if (den < fl)
						den = fl;
					neg = h < y;
					mag = ((neg ? y - h : h - y) << FRAC_BITS) / den;
				end
			end
			LK_XENT: begin
				if (y != 64'd0) begin
					den = (h < fl) ? fl : h;
					neg = 1'b1;
					mag = (y << FRAC_BITS) / den;
				end
			end
			LK_MSE: begin
				neg = h < y;
				mag = neg ? y - h : h - y;
			end
			default: mag = h;
		endcase
		return OUT_W'(neg ? 64'd0 - mag : mag);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= LK_LOGISTIC;
			floor_q   <= EPS_FLOOR_RST;
			grad_q.delete();
			in_flight <= 0;
			errors    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOSS_KIND: kind_q  <= loss_kind_t'(cfg_data[KIND_W-1:0]);
					REG_EPS_FLOOR: floor_q <= cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				grad_q.push_back(loss_grad(prediction, label, kind_q, floor_q));
			if (out_valid && !out_stall) begin
				if (grad_q.size() == 0) begin
					err_cnt++;
					$display("%0t unexpected gradient transfer: expected none actual %0d",
						$time, $signed(gradient));
				end else if (grad_q[0] !== gradient) begin
					err_cnt++;
					$display("%0t gradient mismatch: expected %0d actual %0d",
						$time, $signed(grad_q[0]), $signed(gradient));
					void'(grad_q.pop_front());
				end else begin
					void'(grad_q.pop_front());
				end
			end
			in_flight <= grad_q.size();
			errors    <= err_cnt;
		end
	end

endmodule : lgu_gradient_checker

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for loss_gradient_unit
// Drives directed corner items under every loss kind, then random phases of
// prediction/label pairs under changing loss kind and divisor floor, with
// random gaps on the input side and random stalls on the output side, one
// long output hold-off that backs up the pipeline, and full drains between
// phases. The checker instance predicts and compares; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
	import lgu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS   = FRAC_BITS_DEF;
	localparam int IN_W        = FRAC_BITS + 1;
	localparam int OUT_W       = 2 * FRAC_BITS + 2;
	localparam int LAT         = 2 * FRAC_BITS + 5 + 4;
	localparam int HOLD_CYCLES = 160;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 95;
	localparam int DIR_ITEMS   = 6;
	localparam logic [IN_W-1:0] ONE_IN = IN_W'(1) << FRAC_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic [IN_W-1:0]        prediction = '0;
	logic [IN_W-1:0]        label      = '0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [OUT_W-1:0]       gradient;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index  = REG_LOSS_KIND;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                   quiet      = 1'b0;
	int                     hold_seq   = 0;
	int                     errors;
	int                     in_flight;

	logic [IN_W-1:0] dir_h[DIR_ITEMS] = '{17'h00000, 17'h10000, 17'h00000, 17'h1FFFF,
		17'h00001, 17'h08000};
	logic [IN_W-1:0] dir_y[DIR_ITEMS] = '{17'h00000, 17'h00000, 17'h10000, 17'h12345,
		17'h10000, 17'h08000};
	loss_kind_t phase_kind[PHASES] = '{LK_LOGISTIC, LK_XENT, LK_MSE, LK_LOGISTIC, LK_XENT,
		LK_PASS, LK_LOGISTIC, LK_XENT, LK_MSE, LK_LOGISTIC};

	loss_gradient_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.prediction (prediction),
		.label      (label),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gradient   (gradient),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	lgu_gradient_checker #(.FRAC_BITS(FRAC_BITS)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.prediction (prediction),
		.label      (label),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gradient   (gradient),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.in_flight  (in_flight)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [IN_W-1:0] pick_fraction();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return ONE_IN;
		else if (r < 32)
			return IN_W'($urandom_range(int'(ONE_IN) + 1, (1 << IN_W) - 1));
		else if (r < 42)
			return IN_W'($urandom_range(1, 64));
		else if (r < 52)
			return IN_W'($urandom_range(int'(ONE_IN) - 64, int'(ONE_IN) - 1));
		else
			return IN_W'($urandom_range(0, int'(ONE_IN) - 1));
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(logic [IN_W-1:0] h, logic [IN_W-1:0] y);
		in_valid   <= 1'b1;
		prediction <= h;
		label      <= y;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait until every queued gradient has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (LAT) @(posedge clk);
	endtask

	// output side: random stalls, quiet stretches, one long hold-off on request
	initial begin
		int n;
		int r;
		int hold_done;
		hold_done = 0;
		forever begin
			if (hold_seq != hold_done) begin
				hold_done = hold_seq;
				out_stall <= 1'b1;
				n = HOLD_CYCLES;
			end else if (quiet) begin
				out_stall <= 1'b0;
				n = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 8);
				end else if (r < 88) begin
					out_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else if (r < 97) begin
					out_stall <= 1'b1;
					n = $urandom_range(4, 12);
				end else begin
					out_stall <= 1'b1;
					n = $urandom_range(20, 60);
				end
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		logic [IN_W-1:0]       h;
		logic [IN_W-1:0]       y;
		logic [CFG_DATA_W-1:0] fl;
		int                    gap;
		int                    r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 4; k++) begin
			write_reg(REG_LOSS_KIND, CFG_DATA_W'(loss_kind_t'(k)));
			for (int i = 0; i < DIR_ITEMS; i++)
				send_item(dir_h[i], dir_y[i]);
			settle();
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0, 4:    fl = 16'hFFFF;
				1, 3:    fl = 16'h0000;
				6, 7:    fl = CFG_DATA_W'($urandom_range(1, 255));
				9:       fl = 16'h0001;
				default: fl = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
			endcase
			write_reg(REG_LOSS_KIND, CFG_DATA_W'(phase_kind[p]));
			write_reg(REG_EPS_FLOOR, fl);
			if (p == 3)
				write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
			if (p == 7)
				write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
			quiet <= (p == 6);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 30) begin
					quiet    <= 1'b1;
					hold_seq <= hold_seq + 1;
				end
				if (p == 4 && i == 50)
					settle();
				h = pick_fraction();
				y = ($urandom_range(0, 99) < 15) ? h : pick_fraction();
				send_item(h, y);
				if (!quiet) begin
					r = $urandom_range(0, 99);
					if (r < 50)
						gap = 0;
					else if (r < 85)
						gap = $urandom_range(1, 3);
					else if (r < 97)
						gap = $urandom_range(4, 10);
					else
						gap = $urandom_range(15, 30);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
			settle();
			quiet <= 1'b0;
		end

		if (errors == 0 && in_flight == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule : tb

FILE: files.f
rtl/lgu_pkg.sv
rtl/loss_gradient_unit.sv
tb/lgu_gradient_checker.sv
tb/tb.sv
